@@ hdl/ltc_pkg.sv @@
// ltc_pkg: shared constants and types for the lru tag cache
// no dependencies; used by lru_tag_cache
package ltc_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int DEF_KEY_W   = 32;
   localparam int DEF_DATA_W  = 32;

   // capacity register
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request commands
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOK   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

@@ hdl/lru_tag_cache.sv @@
// lru_tag_cache: fully associative cache with least-recently-used replacement
// depends on ltc_pkg and ltc_cell
//
// Usage: raise start with req_command (get or put), req_key_tag and
// req_value_in; the item is taken at a clock edge where start is high and
// busy is low. Exactly one result follows: rsp_strobe is high for one cycle
// with rsp_hit, rsp_value_out, rsp_evicted and rsp_evicted_key valid. The
// receiver cannot stall and must take the result in that cycle.
// Entries sit in a chain of cells ordered by recency; the least recent one
// is the last valid cell. A lookup compares all cells in parallel.
// Sequence: accept, a compare in the look state, then an update state in
// which the result is shown; the next item is taken only once the cache is
// idle again, set by the registered compare followed by the chain shift.
// csr_write_en with csr_write_data sets the capacity; write only while
// idle. A capacity of 0 acts as 1, above ENTRIES acts as ENTRIES.
// Reset (synchronous, active high) empties the cache and sets the capacity
// to 16; no clearing pass is needed.
module lru_tag_cache #(
   parameter int ENTRIES = ltc_pkg::DEF_ENTRIES,
   parameter int KEY_W   = ltc_pkg::DEF_KEY_W,
   parameter int DATA_W  = ltc_pkg::DEF_DATA_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_command,
   input  logic [KEY_W-1:0]         req_key_tag,
   input  logic [DATA_W-1:0]        req_value_in,
   input  logic                     csr_write_en,
   input  logic [ltc_pkg::CAP_W-1:0] csr_write_data,
   output logic                     rsp_strobe,
   output logic                     rsp_hit,
   output logic [DATA_W-1:0]        rsp_value_out,
   output logic                     rsp_evicted,
   output logic [KEY_W-1:0]         rsp_evicted_key
);

   localparam int CNT_W = $clog2(ENTRIES+1);
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int EW    = (CNT_W > ltc_pkg::CAP_W) ? CNT_W : ltc_pkg::CAP_W;

   ltc_pkg::state_type state_ff, state_in;

   logic [ltc_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   // latched request
   logic              cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] val_ff;

   // lookup outcome
   logic              hit_ff, hit_in;
   logic              evict_ff, evict_in;
   logic [DATA_W-1:0] hit_data_ff, hit_data_in;
   logic [CNT_W-1:0]  stop_ff, stop_in;

   // result registers
   logic              strobe_ff;
   logic              out_hit_ff;
   logic [DATA_W-1:0] out_value_ff;
   logic              out_evicted_ff;
   logic [KEY_W-1:0]  out_evkey_ff;

   // cell chain wiring
   logic              cell_valid   [ENTRIES];
   logic [KEY_W-1:0]  cell_key     [ENTRIES];
   logic [DATA_W-1:0] cell_data    [ENTRIES];
   logic              cell_match   [ENTRIES];
   logic [DATA_W-1:0] cell_mdata   [ENTRIES];
   logic [KEY_W-1:0]  cell_selkey  [ENTRIES];

   logic              accept;
   logic              update;
   logic [CNT_W-1:0]  sel_pos;
   logic [DATA_W-1:0] new_data;
   logic              any_match;
   logic [IDX_W-1:0]  match_pos;
   logic [DATA_W-1:0] match_data;
   logic [KEY_W-1:0]  last_key;
   logic [EW-1:0]     cap_ext;
   logic [EW-1:0]     eff_cap;
   logic              full;

   assign accept = start && (state_ff == ltc_pkg::ST_IDLE);
   assign busy   = (state_ff != ltc_pkg::ST_IDLE);
   assign update = (state_ff == ltc_pkg::ST_UPDATE) &&
                   (hit_ff || (cmd_ff == ltc_pkg::CMD_PUT));

   // least recent valid entry sits at count-1
   assign sel_pos  = count_ff - CNT_W'(1);
   assign new_data = (cmd_ff == ltc_pkg::CMD_PUT) ? val_ff : hit_data_ff;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         logic              pv;
         logic [KEY_W-1:0]  pk;
         logic [DATA_W-1:0] pd;
         if (g == 0) begin : g_head
            // head of the chain takes the promoted or inserted entry
            assign pv = 1'b1;
            assign pk = key_ff;
            assign pd = new_data;
         end else begin : g_body
            assign pv = cell_valid[g-1];
            assign pk = cell_key[g-1];
            assign pd = cell_data[g-1];
         end
         ltc_cell #(
            .IDX     (g),
            .ENTRIES (ENTRIES),
            .KEY_W   (KEY_W),
            .DATA_W  (DATA_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .update     (update),
            .stop       (stop_ff),
            .sel        (sel_pos),
            .cmp_key    (key_ff),
            .prev_valid (pv),
            .prev_key   (pk),
            .prev_data  (pd),
            .valid      (cell_valid[g]),
            .key        (cell_key[g]),
            .data       (cell_data[g]),
            .match      (cell_match[g]),
            .match_data (cell_mdata[g]),
            .sel_key    (cell_selkey[g])
         );
      end
   endgenerate

   // keys are unique among valid cells, so matches are one-hot
   always_comb begin
      any_match  = 1'b0;
      match_pos  = '0;
      match_data = '0;
      last_key   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         any_match  = any_match | cell_match[i];
         match_pos  = match_pos | (IDX_W'(i) & {IDX_W{cell_match[i]}});
         match_data = match_data | cell_mdata[i];
         last_key   = last_key | cell_selkey[i];
      end
   end

   always_comb begin
      cap_ext = EW'(capacity_ff);
      if (capacity_ff == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(ENTRIES)) begin
         eff_cap = EW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full = (EW'(count_ff) >= eff_cap) && (count_ff != '0);

   always_comb begin
      hit_in      = hit_ff;
      evict_in    = evict_ff;
      hit_data_in = hit_data_ff;
      stop_in     = stop_ff;
      if (state_ff == ltc_pkg::ST_LOOK) begin
         hit_in      = any_match;
         hit_data_in = match_data;
         evict_in    = !any_match && (cmd_ff == ltc_pkg::CMD_PUT) && full;
         priority if (any_match) begin
            stop_in = CNT_W'(match_pos);
         end else if ((cmd_ff == ltc_pkg::CMD_PUT) && full) begin
            stop_in = sel_pos;
         end else begin
            stop_in = count_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ltc_pkg::ST_IDLE: begin
            if (start) state_in = ltc_pkg::ST_LOOK;
         end
         ltc_pkg::ST_LOOK: begin
            state_in = ltc_pkg::ST_UPDATE;
         end
         ltc_pkg::ST_UPDATE: begin
            state_in = ltc_pkg::ST_IDLE;
         end
         default: begin
            state_in = ltc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if ((state_ff == ltc_pkg::ST_UPDATE) && (cmd_ff == ltc_pkg::CMD_PUT) &&
          !hit_ff && !evict_ff) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign capacity_in = csr_write_en ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ltc_pkg::ST_IDLE;
         count_ff    <= '0;
         capacity_ff <= ltc_pkg::CAP_RESET;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         capacity_ff <= capacity_in;
         strobe_ff   <= (state_ff == ltc_pkg::ST_LOOK);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         key_ff <= req_key_tag;
         val_ff <= req_value_in;
      end
      hit_ff      <= hit_in;
      evict_ff    <= evict_in;
      hit_data_ff <= hit_data_in;
      stop_ff     <= stop_in;
      if (state_ff == ltc_pkg::ST_LOOK) begin
         out_hit_ff     <= any_match;
         out_value_ff   <= (cmd_ff == ltc_pkg::CMD_GET) ? match_data : '0;
         out_evicted_ff <= evict_in;
         out_evkey_ff   <= evict_in ? last_key : '0;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_value_out   = out_value_ff;
   assign rsp_evicted     = out_evicted_ff;
   assign rsp_evicted_key = out_evkey_ff;

endmodule

@@ hdl/ltc_cell.sv @@
// ltc_cell: one position of the recency stack (position IDX, 0 = most recent)
// compares its key, and on update loads the entry of the position above it
// depends on nothing outside this file
module ltc_cell #(
   parameter int IDX     = 0,
   parameter int ENTRIES = 16,
   parameter int KEY_W   = 32,
   parameter int DATA_W  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             update,
   input  logic [$clog2(ENTRIES+1)-1:0]     stop,
   input  logic [$clog2(ENTRIES+1)-1:0]     sel,
   input  logic [KEY_W-1:0]                 cmp_key,
   input  logic                             prev_valid,
   input  logic [KEY_W-1:0]                 prev_key,
   input  logic [DATA_W-1:0]                prev_data,
   output logic                             valid,
   output logic [KEY_W-1:0]                 key,
   output logic [DATA_W-1:0]                data,
   output logic                             match,
   output logic [DATA_W-1:0]                match_data,
   output logic [KEY_W-1:0]                 sel_key
);

   localparam int CNT_W = $clog2(ENTRIES+1);
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              load;

   // positions at or above the stop point take their neighbor's entry
   assign load = update && (stop >= MY_POS);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = prev_valid;
         key_in   = prev_key;
         data_in  = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign valid      = valid_ff;
   assign key        = key_ff;
   assign data       = data_ff;
   assign match      = valid_ff && (key_ff == cmp_key);
   assign match_data = data_ff & {DATA_W{match}};
   assign sel_key    = key_ff & {KEY_W{sel == MY_POS}};

endmodule
